@@ hdl/resp_request_parser_unit_defines.svh @@
// Assertion macros shared by the request parser modules.
`ifndef RESP_REQUEST_PARSER_UNIT_DEFINES_SVH
`define RESP_REQUEST_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define RRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/rrp_pkg.sv @@
// Shared types and constants of the request parser.
`default_nettype none

package rrp_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int COUNT_W      = $clog2(MAX_ELEMENTS + 1);
  localparam int INDEX_W      = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int LINE_W       = 21;

  localparam logic [LINE_W-1:0] LINE_LEN_RESET = 21'd4096;

  // classified-item queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_ARRAY_HDR    = 3'd1,
    ERR_BULK_HDR     = 3'd2,
    ERR_LEN_MISMATCH = 3'd3,
    ERR_LINE_LONG    = 3'd4,
    ERR_COUNT_OVER   = 3'd5
  } err_t;

  // one input byte with its character class decoded
  typedef struct packed {
    logic [7:0] data;
    logic       is_star;
    logic       is_dollar;
    logic       is_cr;
    logic       is_lf;
    logic       is_digit;
    logic [3:0] digit;
  } class_item_t;

endpackage

`default_nettype wire

@@ hdl/rrp_front.sv @@
// Input stage: takes bytes and registers them with their character class.
`default_nettype none

module rrp_front
  import rrp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  output logic             item_valid,
  input  wire logic        item_ready,
  output class_item_t      item
);

  class_item_t cls;

  always_comb begin
    cls.data      = in_byte;
    cls.is_star   = (in_byte == CH_STAR);
    cls.is_dollar = (in_byte == CH_DOLLAR);
    cls.is_cr     = (in_byte == CH_CR);
    cls.is_lf     = (in_byte == CH_LF);
    cls.is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    cls.digit     = 4'(in_byte - CH_ZERO);
  end

  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
      item       <= cls;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rrp_fifo.sv @@
// Short queue of classified items between the front and the back.
`default_nettype none
`include "resp_request_parser_unit_defines.svh"

module rrp_fifo
  import rrp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire class_item_t  push_item,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output class_item_t       pop_item
);

  class_item_t       slots [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr;
  logic [Q_AW-1:0]   rd_ptr;
  logic [Q_CW-1:0]   count;
  logic              push_fire;
  logic              pop_fire;

  assign push_ready = (count != Q_CW'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push_fire, pop_fire})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `RRP_ASSERT_IMP(a_fifo_bound, 1'b1, count <= Q_CW'(Q_DEPTH), "queue count over depth")

endmodule

`default_nettype wire

@@ hdl/rrp_back.sv @@
// Parse engine: per-byte state update and the result register.
`default_nettype none
`include "resp_request_parser_unit_defines.svh"

module rrp_back
  import rrp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [LINE_W-1:0]   max_line_len,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire class_item_t         item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     payload_valid,
  output logic [7:0]               payload_byte,
  output logic [INDEX_W-1:0]       element_index,
  output logic                     header_done,
  output logic [COUNT_W-1:0]       element_count,
  output logic                     element_done,
  output logic                     request_done,
  output logic [2:0]               error_code
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESYNC,
    S_ARRAY,
    S_BSTART,
    S_BHDR,
    S_BODY
  } mode_t;

  mode_t               mode, mode_next;
  logic                pending_cr, pending_cr_next;
  logic                digit_seen, digit_seen_next;
  logic [COUNT_W-1:0]  count_accum, count_accum_next;
  logic [COUNT_W-1:0]  elements_left, elements_left_next;
  logic [INDEX_W-1:0]  current_index, current_index_next;
  logic [LINE_W-1:0]   bulk_length, bulk_length_next;
  logic [LINE_W-1:0]   byte_counter, byte_counter_next;

  logic                pop;
  logic                starting;
  logic                in_elem;
  logic                in_line;
  logic [LINE_W:0]     n_line;
  logic                line_over;
  logic [COUNT_W+3:0]  cnt_v;
  logic [LINE_W+3:0]   blen_v;
  logic [LINE_W+4:0]   blen_need;
  logic [COUNT_W-1:0]  left_dec;

  logic                r_pv;
  logic [7:0]          r_pb;
  logic [INDEX_W-1:0]  r_idx;
  logic                r_hd;
  logic [COUNT_W-1:0]  r_cnt;
  logic                r_ed;
  logic                r_rd;
  err_t                r_err;
  err_t                err_q;

  assign pop        = item_valid && (!out_valid || out_ready);
  assign item_ready = !out_valid || out_ready;
  assign error_code = err_q;

  always_comb begin
    case (mode)
      S_ARRAY, S_BSTART, S_BHDR, S_BODY: starting = 1'b0;
      default:                           starting = 1'b1;
    endcase
    in_elem = (mode == S_BSTART) || (mode == S_BHDR) || (mode == S_BODY);
    in_line = !starting || item.is_star;
    // a new line starts at the star and at each dollar
    if (starting || mode == S_BSTART) begin
      n_line = (LINE_W+1)'(1);
    end else begin
      n_line = {1'b0, byte_counter} + (LINE_W+1)'(1);
    end
    line_over = in_line && (n_line > {1'b0, max_line_len});

    // times ten plus digit, by shift and add
    cnt_v  = ({4'b0000, count_accum} << 3) + ({4'b0000, count_accum} << 1)
           + {{COUNT_W{1'b0}}, item.digit};
    blen_v = ({4'b0000, bulk_length} << 3) + ({4'b0000, bulk_length} << 1)
           + {{LINE_W{1'b0}}, item.digit};
    blen_need = {1'b0, blen_v} + (LINE_W+5)'(2);
    left_dec  = elements_left - COUNT_W'(1);
  end

  always_comb begin
    mode_next          = mode;
    pending_cr_next    = pending_cr;
    digit_seen_next    = digit_seen;
    count_accum_next   = count_accum;
    elements_left_next = elements_left;
    current_index_next = current_index;
    bulk_length_next   = bulk_length;
    byte_counter_next  = byte_counter;
    r_pv  = 1'b0;
    r_pb  = 8'h00;
    r_idx = in_elem ? current_index : '0;
    r_hd  = 1'b0;
    r_cnt = '0;
    r_ed  = 1'b0;
    r_rd  = 1'b0;
    r_err = ERR_NONE;

    if (in_line && !line_over) begin
      byte_counter_next = n_line[LINE_W-1:0];
    end

    if (line_over) begin
      r_err = ERR_LINE_LONG;
    end else begin
      case (mode)
        S_IDLE: begin
          if (item.is_star) begin
            mode_next        = S_ARRAY;
            pending_cr_next  = 1'b0;
            digit_seen_next  = 1'b0;
            count_accum_next = '0;
          end else begin
            r_err = ERR_ARRAY_HDR;
          end
        end
        S_ARRAY: begin
          if (pending_cr) begin
            if (item.is_lf) begin
              r_hd              = 1'b1;
              r_cnt             = count_accum;
              pending_cr_next   = 1'b0;
              byte_counter_next = '0;
              if (count_accum == '0) begin
                r_rd      = 1'b1;
                mode_next = S_IDLE;
              end else begin
                elements_left_next = count_accum;
                current_index_next = '0;
                mode_next          = S_BSTART;
              end
            end else begin
              r_err = ERR_ARRAY_HDR;
            end
          end else if (item.is_digit) begin
            if (cnt_v > (COUNT_W+4)'(MAX_ELEMENTS)) begin
              r_err = ERR_COUNT_OVER;
            end else begin
              count_accum_next = cnt_v[COUNT_W-1:0];
              digit_seen_next  = 1'b1;
            end
          end else if (item.is_cr && digit_seen) begin
            pending_cr_next = 1'b1;
          end else begin
            r_err = ERR_ARRAY_HDR;
          end
        end
        S_BSTART: begin
          if (item.is_dollar) begin
            mode_next        = S_BHDR;
            digit_seen_next  = 1'b0;
            pending_cr_next  = 1'b0;
            bulk_length_next = '0;
          end else begin
            r_err = ERR_BULK_HDR;
          end
        end
        S_BHDR: begin
          if (pending_cr) begin
            if (item.is_lf) begin
              mode_next         = S_BODY;
              pending_cr_next   = 1'b0;
              byte_counter_next = '0;
            end else begin
              r_err = ERR_BULK_HDR;
            end
          end else if (item.is_digit) begin
            // body plus its CR LF must fit in a line
            if (blen_need > {5'b00000, max_line_len}) begin
              r_err = ERR_LINE_LONG;
            end else begin
              bulk_length_next = blen_v[LINE_W-1:0];
              digit_seen_next  = 1'b1;
            end
          end else if (item.is_cr && digit_seen) begin
            pending_cr_next = 1'b1;
          end else begin
            r_err = ERR_BULK_HDR;
          end
        end
        S_BODY: begin
          if (pending_cr) begin
            if (item.is_lf) begin
              r_ed               = 1'b1;
              pending_cr_next    = 1'b0;
              byte_counter_next  = '0;
              elements_left_next = left_dec;
              if (left_dec == '0) begin
                r_rd      = 1'b1;
                mode_next = S_IDLE;
              end else begin
                current_index_next = current_index + 1'b1;
                mode_next          = S_BSTART;
              end
            end else begin
              r_err = ERR_LEN_MISMATCH;
            end
          end else if (byte_counter < bulk_length) begin
            r_pv = 1'b1;
            r_pb = item.data;
          end else if (item.is_cr) begin
            pending_cr_next = 1'b1;
          end else begin
            r_err = ERR_LEN_MISMATCH;
          end
        end
        default: begin
          // resync: wait silently for a new star
          if (item.is_star) begin
            mode_next        = S_ARRAY;
            pending_cr_next  = 1'b0;
            digit_seen_next  = 1'b0;
            count_accum_next = '0;
          end
        end
      endcase
    end

    if (r_err != ERR_NONE) begin
      mode_next          = S_RESYNC;
      pending_cr_next    = 1'b0;
      digit_seen_next    = 1'b0;
      count_accum_next   = '0;
      elements_left_next = '0;
      current_index_next = '0;
      bulk_length_next   = '0;
      byte_counter_next  = '0;
      r_pv  = 1'b0;
      r_pb  = 8'h00;
      r_hd  = 1'b0;
      r_cnt = '0;
      r_ed  = 1'b0;
      r_rd  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= S_IDLE;
      pending_cr    <= 1'b0;
      digit_seen    <= 1'b0;
      count_accum   <= '0;
      elements_left <= '0;
      current_index <= '0;
      bulk_length   <= '0;
      byte_counter  <= '0;
      out_valid     <= 1'b0;
    end else if (pop) begin
      mode          <= mode_next;
      pending_cr    <= pending_cr_next;
      digit_seen    <= digit_seen_next;
      count_accum   <= count_accum_next;
      elements_left <= elements_left_next;
      current_index <= current_index_next;
      bulk_length   <= bulk_length_next;
      byte_counter  <= byte_counter_next;
      out_valid     <= 1'b1;
      payload_valid <= r_pv;
      payload_byte  <= r_pb;
      element_index <= r_idx;
      header_done   <= r_hd;
      element_count <= r_cnt;
      element_done  <= r_ed;
      request_done  <= r_rd;
      err_q         <= r_err;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `RRP_ASSERT_IMP(a_err_quiet,
    out_valid && (err_q != ERR_NONE),
    !payload_valid && !header_done && !element_done && !request_done
      && (element_count == '0),
    "error item carries other flags")
  `RRP_ASSERT_IMP(a_done_src,
    out_valid && request_done,
    header_done || element_done,
    "request end without header or element end")
  `RRP_ASSERT_NXT(a_done_idle,
    pop && r_rd,
    mode == S_IDLE,
    "parser not idle after request end")

endmodule

`default_nettype wire

@@ hdl/resp_request_parser_unit.sv @@
// Top level of the byte-serial array-of-bulk-strings request parser.
`default_nettype none

// Request parser. Bytes enter on in_valid/in_ready, one per item, and each
// byte gives exactly one result item on out_valid/out_ready. A request is
// '*', the decimal element count and CR LF, then per element '$', the decimal
// body length and CR LF, the body and CR LF. Body bytes come out with
// payload_valid and their element_index; header_done (with element_count),
// element_done and request_done mark the ends. An error_code is given on the
// first bad byte; the parser then drops bytes silently until the next '*'.
// Throughput is one byte per cycle sustained while out_ready stays high. A
// byte is registered in the front, then written into the queue, and its
// result is registered by the parse engine, which updates its parse state at
// the same edge as it registers that result, on every accepted byte. A
// four-entry queue between the classifying front and the parse engine lets
// each side stall independently. max_line_len (cfg_wr_en/cfg_wr_data, reset
// 4096) bounds any header line or body including its CR LF; write it only
// while the parser holds no unfinished item. No clearing pass after reset.
module resp_request_parser_unit
  import rrp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [LINE_W-1:0]   cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_byte,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     payload_valid,
  output logic [7:0]               payload_byte,
  output logic [INDEX_W-1:0]       element_index,
  output logic                     header_done,
  output logic [COUNT_W-1:0]       element_count,
  output logic                     element_done,
  output logic                     request_done,
  output logic [2:0]               error_code
);

  logic [LINE_W-1:0] max_line_len;

  logic        f_valid;
  logic        f_ready;
  class_item_t f_item;
  logic        q_valid;
  logic        q_ready;
  class_item_t q_item;

  // line length limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_len <= LINE_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_line_len <= cfg_wr_data;
    end
  end

  rrp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  rrp_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  rrp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .max_line_len  (max_line_len),
    .item_valid    (q_valid),
    .item_ready    (q_ready),
    .item          (q_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .payload_valid (payload_valid),
    .payload_byte  (payload_byte),
    .element_index (element_index),
    .header_done   (header_done),
    .element_count (element_count),
    .element_done  (element_done),
    .request_done  (request_done),
    .error_code    (error_code)
  );

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the array-of-bulk-strings request parser.
`timescale 1ns / 100ps

module testbench;
  import rrp_pkg::*;

  // parser modes of the predictor
  typedef enum logic [2:0] {
    PM_IDLE, PM_RESYNC, PM_ARRAY, PM_BSTART, PM_BHDR, PM_BODY
  } parse_mode_t;

  typedef struct packed {
    logic               pv;
    logic [7:0]         pb;
    logic [INDEX_W-1:0] idx;
    logic               hd;
    logic [COUNT_W-1:0] cnt;
    logic               ed;
    logic               rd;
    err_t               err;
  } parse_result_t;

  // Predicts one result per accepted byte and checks the DUT results in order.
  class parse_scoreboard;
    parse_mode_t        mode;
    bit                 cr_seen;
    bit                 dig_seen;
    logic [10:0]        count_acc;
    logic [10:0]        elems_left;
    logic [9:0]         cur_idx;
    logic [LINE_W-1:0]  bulk_len;
    logic [LINE_W-1:0]  byte_cnt;
    logic [LINE_W-1:0]  line_len;
    parse_result_t      expected_q[$];
    int unsigned        fails;
    int unsigned        result_no;

    function new();
      mode       = PM_IDLE;
      cr_seen    = 0;
      dig_seen   = 0;
      count_acc  = '0;
      elems_left = '0;
      cur_idx    = '0;
      bulk_len   = '0;
      byte_cnt   = '0;
      line_len   = LINE_LEN_RESET;
      fails      = 0;
      result_no  = 0;
    endfunction

    function void start_array();
      mode      = PM_ARRAY;
      cr_seen   = 0;
      dig_seen  = 0;
      count_acc = '0;
    endfunction

    function parse_result_t step(logic [7:0] b);
      parse_result_t r;
      bit            starting;
      bit            in_line;
      bit            is_dig;
      int unsigned   n;
      int unsigned   v;
      r        = '0;
      r.err    = ERR_NONE;
      starting = (mode == PM_IDLE || mode == PM_RESYNC);
      in_line  = !starting || b == CH_STAR;
      is_dig   = (b >= CH_ZERO && b <= CH_NINE);
      if (mode == PM_BSTART || mode == PM_BHDR || mode == PM_BODY) r.idx = cur_idx;

      // line length check comes first; '$' opens a fresh line
      if (in_line) begin
        n = starting ? 1 : byte_cnt + 1;
        if (mode == PM_BSTART) n = 1;
        if (n > line_len) r.err = ERR_LINE_LONG;
        else byte_cnt = n[LINE_W-1:0];
      end

      if (r.err == ERR_NONE) begin
        case (mode)
          PM_IDLE: begin
            if (b == CH_STAR) start_array();
            else r.err = ERR_ARRAY_HDR;
          end
          PM_ARRAY: begin
            if (cr_seen) begin
              if (b == CH_LF) begin
                r.hd     = 1;
                r.cnt    = count_acc;
                cr_seen  = 0;
                byte_cnt = '0;
                if (count_acc == 0) begin
                  r.rd = 1;
                  mode = PM_IDLE;
                end else begin
                  elems_left = count_acc;
                  cur_idx    = '0;
                  mode       = PM_BSTART;
                end
              end else begin
                r.err = ERR_ARRAY_HDR;
              end
            end else if (is_dig) begin
              v = count_acc * 10 + (b - CH_ZERO);
              if (v > MAX_ELEMENTS) begin
                r.err = ERR_COUNT_OVER;
              end else begin
                count_acc = v[10:0];
                dig_seen  = 1;
              end
            end else if (b == CH_CR && dig_seen) begin
              cr_seen = 1;
            end else begin
              r.err = ERR_ARRAY_HDR;
            end
          end
          PM_BSTART: begin
            if (b == CH_DOLLAR) begin
              mode     = PM_BHDR;
              dig_seen = 0;
              cr_seen  = 0;
              bulk_len = '0;
            end else begin
              r.err = ERR_BULK_HDR;
            end
          end
          PM_BHDR: begin
            if (cr_seen) begin
              if (b == CH_LF) begin
                mode     = PM_BODY;
                cr_seen  = 0;
                byte_cnt = '0;
              end else begin
                r.err = ERR_BULK_HDR;
              end
            end else if (is_dig) begin
              v = bulk_len * 10 + (b - CH_ZERO);
              // body plus CR LF must fit the line limit
              if (v + 2 > line_len) begin
                r.err = ERR_LINE_LONG;
              end else begin
                bulk_len = v[LINE_W-1:0];
                dig_seen = 1;
              end
            end else if (b == CH_CR && dig_seen) begin
              cr_seen = 1;
            end else begin
              r.err = ERR_BULK_HDR;
            end
          end
          PM_BODY: begin
            if (cr_seen) begin
              if (b == CH_LF) begin
                r.ed       = 1;
                cr_seen    = 0;
                byte_cnt   = '0;
                elems_left = elems_left - 11'd1;
                if (elems_left == 0) begin
                  r.rd = 1;
                  mode = PM_IDLE;
                end else begin
                  cur_idx = cur_idx + 10'd1;
                  mode    = PM_BSTART;
                end
              end else begin
                r.err = ERR_LEN_MISMATCH;
              end
            end else if ((byte_cnt - 21'd1) < bulk_len) begin
              // binary-safe body byte
              r.pv = 1;
              r.pb = b;
            end else if (b == CH_CR) begin
              cr_seen = 1;
            end else begin
              r.err = ERR_LEN_MISMATCH;
            end
          end
          default: begin
            // resync: drop everything until a new star
            if (b == CH_STAR) start_array();
          end
        endcase
      end

      // error clears the parse state and all flags; index stays as it was
      if (r.err != ERR_NONE) begin
        mode       = PM_RESYNC;
        cr_seen    = 0;
        dig_seen   = 0;
        count_acc  = '0;
        elems_left = '0;
        cur_idx    = '0;
        bulk_len   = '0;
        byte_cnt   = '0;
        r.pv       = 0;
        r.pb       = '0;
        r.hd       = 0;
        r.cnt      = '0;
        r.ed       = 0;
        r.rd       = 0;
      end
      return r;
    endfunction

    function void note_byte(logic [7:0] b);
      expected_q.push_back(step(b));
    endfunction

    task report_mismatch(string what);
      fails++;
      if (fails <= 200) $display("MISMATCH result %0d: %s", result_no, what);
    endtask

    task check_result(parse_result_t got);
      parse_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no byte waiting");
      end else begin
        want = expected_q.pop_front();
        if (got.pv !== want.pv)
          report_mismatch($sformatf("payload_valid %0b want %0b", got.pv, want.pv));
        if (got.pb !== want.pb)
          report_mismatch($sformatf("payload_byte %0h want %0h", got.pb, want.pb));
        if (got.idx !== want.idx)
          report_mismatch($sformatf("element_index %0d want %0d", got.idx, want.idx));
        if (got.hd !== want.hd)
          report_mismatch($sformatf("header_done %0b want %0b", got.hd, want.hd));
        if (got.cnt !== want.cnt)
          report_mismatch($sformatf("element_count %0d want %0d", got.cnt, want.cnt));
        if (got.ed !== want.ed)
          report_mismatch($sformatf("element_done %0b want %0b", got.ed, want.ed));
        if (got.rd !== want.rd)
          report_mismatch($sformatf("request_done %0b want %0b", got.rd, want.rd));
        if (got.err !== want.err)
          report_mismatch($sformatf("error_code %0d want %0d", got.err, want.err));
      end
      result_no++;
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [LINE_W-1:0]  cfg_wr_data;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_byte;
  logic               out_valid;
  logic               out_ready;
  logic               payload_valid;
  logic [7:0]         payload_byte;
  logic [INDEX_W-1:0] element_index;
  logic               header_done;
  logic [COUNT_W-1:0] element_count;
  logic               element_done;
  logic               request_done;
  logic [2:0]         error_code;

  resp_request_parser_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .payload_valid (payload_valid),
    .payload_byte  (payload_byte),
    .element_index (element_index),
    .header_done   (header_done),
    .element_count (element_count),
    .element_done  (element_done),
    .request_done  (request_done),
    .error_code    (error_code)
  );

  parse_scoreboard sb = new();

  logic [7:0]  stream[$];      // bytes waiting to be sent
  int unsigned gen_line_len;   // limit the generator aims at
  int          send_idle;      // percent of cycles the sender idles
  int          recv_idle;      // percent of cycles the receiver stalls
  bit          hold_req;
  logic [7:0]  marker_bytes[6] = '{CH_STAR, CH_DOLLAR, 8'h2D, CH_CR, CH_LF, CH_ZERO};

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // hard limit on run time
  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = 400;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // monitor both handshakes on pre-edge values
  always @(posedge clk) begin
    parse_result_t got;
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(in_byte);
      if (out_valid && out_ready) begin
        got.pv  = payload_valid;
        got.pb  = payload_byte;
        got.idx = element_index;
        got.hd  = header_done;
        got.cnt = element_count;
        got.ed  = element_done;
        got.rd  = request_done;
        got.err = err_t'(error_code);
        sb.check_result(got);
      end
    end
  end

  function void push_str(string s);
    foreach (s[i]) stream.push_back(s[i]);
  endfunction

  function void push_crlf();
    stream.push_back(CH_CR);
    stream.push_back(CH_LF);
  endfunction

  function void push_num(int unsigned v, int zeros);
    repeat (zeros) stream.push_back(CH_ZERO);
    push_str($sformatf("%0d", v));
  endfunction

  // One request, mostly well formed, sometimes cut short, oversized or damaged.
  function void build_request();
    int unsigned count;
    int unsigned len;
    int          nelem;
    int          p;
    if ($urandom_range(99) < 5) begin
      repeat ($urandom_range(1, 4)) stream.push_back(8'($urandom_range(255)));
      return;
    end
    if ($urandom_range(99) < 8) begin
      // near the element bound: header only plus a few elements
      count = $urandom_range(1020, 1100);
      nelem = 3;
    end else begin
      count = $urandom_range(0, 4);
      nelem = count;
    end
    stream.push_back(CH_STAR);
    push_num(count, ($urandom_range(15) == 0) ? $urandom_range(1, 30) : 0);
    push_crlf();
    for (int k = 0; k < nelem; k++) begin
      stream.push_back(CH_DOLLAR);
      if (gen_line_len <= 64 && $urandom_range(7) == 0)
        len = $urandom_range(gen_line_len - 4, gen_line_len - 1);
      else
        len = $urandom_range(0, 6);
      push_num(len, ($urandom_range(15) == 0) ? $urandom_range(1, 30) : 0);
      push_crlf();
      repeat (len) begin
        if ($urandom_range(3) == 0) stream.push_back($urandom_range(1) ? CH_CR : CH_LF);
        else stream.push_back(8'($urandom_range(255)));
      end
      push_crlf();
    end
    if ($urandom_range(6) == 0) begin
      p = $urandom_range(stream.size() - 1);
      case ($urandom_range(3))
        0: stream[p] = 8'($urandom_range(255));
        1: stream[p] = marker_bytes[$urandom_range(5)];
        2: stream.delete(p);
        default: stream.insert(p, 8'($urandom_range(255)));
      endcase
    end
  endfunction

  task send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task send_stream();
    while (stream.size() != 0) send_byte(stream.pop_front());
  endtask

  // wait for every result, then for the pipeline to settle
  task drain();
    in_valid <= 1'b0;
    // let the monitor note a byte accepted at the current edge first
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task set_line_len(logic [LINE_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.line_len  = v;
    gen_line_len = 32'(v);
  endtask

  task run_phase(int unsigned target, int s_idle, int r_idle);
    int unsigned sent;
    sent      = 0;
    send_idle = s_idle;
    recv_idle = r_idle;
    while (sent < target) begin
      build_request();
      sent += stream.size();
      send_stream();
    end
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    in_valid     <= 1'b0;
    in_byte      <= '0;
    hold_req      = 0;
    send_idle     = 23;
    recv_idle     = 63;
    gen_line_len  = 32'(LINE_LEN_RESET);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty array, stray byte, binary body with CR LF and 0xFF,
    // idle stray 0x00, count over bound, bytes dropped while resyncing
    push_str("*0");
    push_crlf();
    push_str("x*1");
    push_crlf();
    push_str("$3");
    push_crlf();
    push_crlf();
    stream.push_back(8'hFF);
    push_crlf();
    stream.push_back(8'h00);
    push_str("*1025$*0");
    push_crlf();
    send_stream();

    // smallest limit: overlong header line, then a too-long bulk length
    set_line_len(21'd4);
    push_str("*10");
    push_crlf();
    push_str("*1");
    push_crlf();
    push_str("$3");
    send_stream();

    set_line_len(21'd24);
    run_phase(310, 23, 63);

    set_line_len(21'd8);
    run_phase(310, 63, 23);

    // largest limit, no idling; the long receiver hold-off backs up the input
    set_line_len(21'd1048576);
    hold_req = 1;
    run_phase(310, 0, 0);

    set_line_len(LINE_LEN_RESET);
    run_phase(40, 0, 0);

    drain();
    if (sb.fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
